@@ sv/grid_segment_collision_check_macros.svh @@
// Assertion macros for the grid segment collision check.
// Used by the port checker; depends on clk and rst_n in the using scope.
`ifndef GRID_SEGMENT_COLLISION_CHECK_MACROS_SVH
`define GRID_SEGMENT_COLLISION_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/gsc_pkg.sv @@
// Shared constants and types for the grid segment collision check.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gsc_pkg;

    localparam int AXIS_CELLS = 256;
    localparam int AXIS_BITS  = 8;
    localparam int SIZE_BITS  = 9;
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 2 * AXIS_BITS;
    localparam int PROD_BITS  = COORD_BITS + SIZE_BITS;
    localparam int DRIFT_BITS = AXIS_BITS + 3;
    localparam int QUEUE_DEPTH = 2;

    // Function codes of an input transaction.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_X_LOW       = 3'd2;
    localparam logic [2:0] CFG_X_HIGH      = 3'd3;
    localparam logic [2:0] CFG_Y_LOW       = 3'd4;
    localparam logic [2:0] CFG_Y_HIGH      = 3'd5;

    // Operations handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_RANGE = 2'd0,
        OP_WRITE = 2'd1,
        OP_WALK  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [AXIS_BITS-1:0] x0;
        logic [AXIS_BITS-1:0] y0;
        logic [AXIS_BITS-1:0] x1;
        logic [AXIS_BITS-1:0] y1;
        logic                 free;
    } cmd_t;

    localparam int CMD_BITS = $bits(cmd_t);

endpackage

@@ sv/gsc_front.sv @@
// Front part: configuration registers, input acceptance and quantization.
// Depends on gsc_pkg; feeds the command queue.
`timescale 1ns / 1ps

module gsc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [gsc_pkg::COORD_BITS-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [gsc_pkg::COORD_BITS-1:0] src_x,
    input  logic [gsc_pkg::COORD_BITS-1:0] src_y,
    input  logic [gsc_pkg::COORD_BITS-1:0] dst_x,
    input  logic [gsc_pkg::COORD_BITS-1:0] dst_y,
    input  logic [gsc_pkg::AXIS_BITS-1:0]  cell_x,
    input  logic [gsc_pkg::AXIS_BITS-1:0]  cell_y,
    input  logic                         cell_free,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output gsc_pkg::cmd_t                cmd
);
    import gsc_pkg::*;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_CHECK = 3'd1;
    localparam logic [2:0] F_DIV   = 3'd2;
    localparam logic [2:0] F_PUSH  = 3'd3;

    logic [2:0]            state_reg, state_next;
    logic [SIZE_BITS-1:0]  gw_reg, gh_reg;
    logic [COORD_BITS-1:0] xl_reg, xh_reg, yl_reg, yh_reg;
    logic [1:0]            func_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, dx_reg, dy_reg;
    logic [AXIS_BITS-1:0]  cx_reg, cy_reg;
    logic                  free_reg;
    logic [1:0]            k_reg, k_next;
    op_t                   op_reg, op_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [SIZE_BITS-1:0]  sh_reg, sh_next;
    logic [SIZE_BITS-1:0]  q_reg, q_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] div_reg, div_next;
    logic [SIZE_BITS-1:0]  n_reg, n_next;
    logic [AXIS_BITS-1:0]  qc_reg [4];

    logic [SIZE_BITS-1:0]  eff_w, eff_h, n_sel;
    logic [COORD_BITS-1:0] c_sel, lo_sel, hi_sel, diff;
    logic [PROD_BITS-1:0]  prod;
    logic                  bad;
    logic [COORD_BITS:0]   trial;
    logic                  ge;
    logic [SIZE_BITS-1:0]  q_new, q_clamp;
    logic                  last_k;
    logic                  qc_we;

    always_comb
    begin
        eff_w = (gw_reg == '0) ? SIZE_BITS'(1) :
                (gw_reg > SIZE_BITS'(AXIS_CELLS)) ? SIZE_BITS'(AXIS_CELLS) : gw_reg;
        eff_h = (gh_reg == '0) ? SIZE_BITS'(1) :
                (gh_reg > SIZE_BITS'(AXIS_CELLS)) ? SIZE_BITS'(AXIS_CELLS) : gh_reg;
        case (k_reg)
            2'd0:    c_sel = sx_reg;
            2'd1:    c_sel = sy_reg;
            2'd2:    c_sel = dx_reg;
            default: c_sel = dy_reg;
        endcase
        lo_sel = k_reg[0] ? yl_reg : xl_reg;
        hi_sel = k_reg[0] ? yh_reg : xh_reg;
        n_sel  = k_reg[0] ? eff_h : eff_w;
        bad    = (hi_sel <= lo_sel) || (c_sel < lo_sel) || (c_sel > hi_sel);
        diff   = c_sel - lo_sel;
        prod   = PROD_BITS'(diff) * PROD_BITS'(n_sel);
        trial  = {rem_reg, sh_reg[SIZE_BITS-1]};
        ge     = trial >= {1'b0, div_reg};
        q_new  = {q_reg[SIZE_BITS-2:0], ge};
        q_clamp = (q_new > n_reg - SIZE_BITS'(1)) ? n_reg - SIZE_BITS'(1) : q_new;
        last_k = (func_reg == FUNC_QUERY) ? (k_reg == 2'd1) : (k_reg == 2'd3);
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        op_next    = op_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        n_next     = n_reg;
        qc_we      = 1'b0;
        in_ready   = 1'b0;
        cmd_valid  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    k_next     = 2'd0;
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                if (func_reg == FUNC_WRITE)
                begin
                    op_next = ({1'b0, cx_reg} < eff_w && {1'b0, cy_reg} < eff_h) ?
                              OP_WRITE : OP_RANGE;
                    state_next = F_PUSH;
                end
                else if (func_reg != FUNC_CHECK && func_reg != FUNC_QUERY)
                begin
                    op_next    = OP_RANGE;
                    state_next = F_PUSH;
                end
                else if (bad)
                begin
                    op_next    = OP_RANGE;
                    state_next = F_PUSH;
                end
                else
                begin
                    op_next    = OP_WALK;
                    rem_next   = prod[PROD_BITS-1:SIZE_BITS];
                    sh_next    = prod[SIZE_BITS-1:0];
                    q_next     = '0;
                    cnt_next   = '0;
                    div_next   = hi_sel - lo_sel;
                    n_next     = n_sel;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next = ge ? COORD_BITS'(trial - {1'b0, div_reg}) : trial[COORD_BITS-1:0];
                sh_next  = {sh_reg[SIZE_BITS-2:0], 1'b0};
                q_next   = q_new;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(SIZE_BITS - 1))
                begin
                    qc_we = 1'b1;
                    if (last_k)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = F_CHECK;
                    end
                end
            end
            F_PUSH:
            begin
                cmd_valid = 1'b1;
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = op_reg;
        cmd.free = free_reg;
        if (func_reg == FUNC_WRITE)
        begin
            cmd.x0 = cx_reg;
            cmd.y0 = cy_reg;
            cmd.x1 = cx_reg;
            cmd.y1 = cy_reg;
        end
        else if (func_reg == FUNC_QUERY)
        begin
            cmd.x0 = qc_reg[0];
            cmd.y0 = qc_reg[1];
            cmd.x1 = qc_reg[0];
            cmd.y1 = qc_reg[1];
        end
        else
        begin
            cmd.x0 = qc_reg[0];
            cmd.y0 = qc_reg[1];
            cmd.x1 = qc_reg[2];
            cmd.y1 = qc_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            gw_reg    <= SIZE_BITS'(AXIS_CELLS);
            gh_reg    <= SIZE_BITS'(AXIS_CELLS);
            xl_reg    <= '0;
            xh_reg    <= '1;
            yl_reg    <= '0;
            yh_reg    <= '1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg <= cfg_data[SIZE_BITS-1:0];
                    CFG_GRID_HEIGHT: gh_reg <= cfg_data[SIZE_BITS-1:0];
                    CFG_X_LOW:       xl_reg <= cfg_data;
                    CFG_X_HIGH:      xh_reg <= cfg_data;
                    CFG_Y_LOW:       yl_reg <= cfg_data;
                    CFG_Y_HIGH:      yh_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            sx_reg   <= src_x;
            sy_reg   <= src_y;
            dx_reg   <= dst_x;
            dy_reg   <= dst_y;
            cx_reg   <= cell_x;
            cy_reg   <= cell_y;
            free_reg <= cell_free;
        end
        k_reg   <= k_next;
        op_reg  <= op_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        n_reg   <= n_next;
        if (qc_we)
        begin
            qc_reg[k_reg] <= q_clamp[AXIS_BITS-1:0];
        end
    end

endmodule

@@ sv/gsc_queue.sv @@
// Short command queue between the front and back parts.
// Depends on gsc_pkg for the command type and depth.
`timescale 1ns / 1ps

module gsc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  gsc_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output gsc_pkg::cmd_t rd_cmd
);
    import gsc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wp_reg, rp_reg;
    logic [PTR_BITS:0]   count_reg, count_next;
    logic                push, pop;

    assign wr_ready = count_reg != (PTR_BITS+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = entry_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= wr_cmd;
        end
    end

endmodule

@@ sv/gsc_back.sv @@
// Back part: occupancy memory, cell writes and the Bresenham walk.
// Depends on gsc_pkg; drains the command queue and owns the result register.
`timescale 1ns / 1ps

module gsc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  gsc_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status
);
    import gsc_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_CHK  = 2'd2;

    logic                         mem [0:(1 << ADDR_BITS) - 1];
    logic                         rdata_reg;

    logic [1:0]                   state_reg, state_next;
    logic                         ov_reg, ov_next;
    logic [1:0]                   st_reg, st_next;
    logic [AXIS_BITS-1:0]         m_reg, m_next, v_reg, v_next;
    logic [AXIS_BITS-1:0]         d0_reg, d0_next, d1_reg, d1_next;
    logic [AXIS_BITS-1:0]         cnt_reg, cnt_next;
    logic                         swap_reg, swap_next, smn_reg, smn_next, svn_reg, svn_next;
    logic signed [DRIFT_BITS-1:0] drift_reg, drift_next;

    logic [AXIS_BITS-1:0]         ax, ay;
    logic                         sw;
    logic signed [DRIFT_BITS-1:0] dt;
    logic [AXIS_BITS-1:0]         cur_x, cur_y;
    logic                         mem_we, mem_re;

    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign cur_x     = swap_reg ? v_reg : m_reg;
    assign cur_y     = swap_reg ? m_reg : v_reg;

    always_comb
    begin
        ax = (cmd.x1 > cmd.x0) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
        ay = (cmd.y1 > cmd.y0) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1;
        sw = ay > ax;
        dt = drift_reg - {2'b00, d1_reg, 1'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        m_next     = m_reg;
        v_next     = v_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        cnt_next   = cnt_reg;
        swap_next  = swap_reg;
        smn_next   = smn_reg;
        svn_next   = svn_reg;
        drift_next = drift_reg;
        cmd_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                cmd_ready = !ov_reg;
                if (cmd_valid && !ov_reg)
                begin
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            mem_we  = 1'b1;
                            st_next = ST_FREE;
                            ov_next = 1'b1;
                        end
                        OP_WALK:
                        begin
                            swap_next  = sw;
                            m_next     = sw ? cmd.y0 : cmd.x0;
                            v_next     = sw ? cmd.x0 : cmd.y0;
                            d0_next    = sw ? ay : ax;
                            d1_next    = sw ? ax : ay;
                            cnt_next   = sw ? ay : ax;
                            smn_next   = sw ? (cmd.y0 > cmd.y1) : (cmd.x0 > cmd.x1);
                            svn_next   = sw ? (cmd.x0 > cmd.x1) : (cmd.y0 > cmd.y1);
                            drift_next = DRIFT_BITS'(sw ? ay : ax);
                            state_next = B_RD;
                        end
                        default:
                        begin
                            st_next = ST_RANGE;
                            ov_next = 1'b1;
                        end
                    endcase
                end
            end
            B_RD:
            begin
                mem_re     = 1'b1;
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (!rdata_reg)
                begin
                    st_next    = ST_BLOCKED;
                    ov_next    = 1'b1;
                    state_next = B_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    st_next    = ST_FREE;
                    ov_next    = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    m_next   = smn_reg ? m_reg - 1'b1 : m_reg + 1'b1;
                    if (dt < 0)
                    begin
                        v_next     = svn_reg ? v_reg - 1'b1 : v_reg + 1'b1;
                        drift_next = dt + $signed({2'b00, d0_reg, 1'b0});
                    end
                    else
                    begin
                        drift_next = dt;
                    end
                    state_next = B_RD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg    <= st_next;
        m_reg     <= m_next;
        v_reg     <= v_next;
        d0_reg    <= d0_next;
        d1_reg    <= d1_next;
        cnt_reg   <= cnt_next;
        swap_reg  <= swap_next;
        smn_reg   <= smn_next;
        svn_reg   <= svn_next;
        drift_reg <= drift_next;
    end

    // Single-bit occupancy memory, address is row then column.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[{cmd.y0, cmd.x0}] <= cmd.free;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[{cur_y, cur_x}];
        end
    end

endmodule

@@ sv/grid_segment_collision_check.sv @@
// Top level of the grid segment collision check: front, command queue, back.
// Depends on gsc_pkg, gsc_front, gsc_queue and gsc_back.
`timescale 1ns / 1ps

// The block holds a 256 by 256 one-bit occupancy map (1 means free) and takes
// one transaction at a time on the input channel: a cell write, a point query
// or a segment check. Each transaction yields exactly one status on the output
// channel. The front part quantizes world points with a shared restoring
// divider, one coordinate after another, each after a setup step. The back
// part walks the segment cell by cell, reading each cell from the registered
// memory before checking it. The command queue lets the front quantize the
// next transaction while the back is still walking, and the result register
// holds a status until it is taken. The map is not cleared by reset; every
// cell must be written before any query or walk reaches it. The user must
// write configuration only while idle; the block itself does not enforce it.

module grid_segment_collision_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [gsc_pkg::COORD_BITS-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic [gsc_pkg::COORD_BITS-1:0] src_x,
    input  logic [gsc_pkg::COORD_BITS-1:0] src_y,
    input  logic [gsc_pkg::COORD_BITS-1:0] dst_x,
    input  logic [gsc_pkg::COORD_BITS-1:0] dst_y,
    input  logic [gsc_pkg::AXIS_BITS-1:0]  cell_x,
    input  logic [gsc_pkg::AXIS_BITS-1:0]  cell_y,
    input  logic                           cell_free,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status
);
    import gsc_pkg::*;

    // Front to queue and queue to back transactions.
    cmd_t fq_cmd, qb_cmd;
    logic fq_valid, fq_ready, qb_valid, qb_ready;

    gsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .src_x     (src_x),
        .src_y     (src_y),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .cell_free (cell_free),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    // The queue decouples quantization from the memory walk.
    gsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    // The back part owns the map and the result register.
    gsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

endmodule

@@ sv/gsc_checker.sv @@
// Port-level checker for the grid segment collision check, bound to the top.
// Depends on grid_segment_collision_check_macros.svh and gsc_pkg.
`timescale 1ns / 1ps

module gsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status
);

`include "grid_segment_collision_check_macros.svh"

    // A waiting result keeps its status.
    `GSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped or changed while stalled")

    // Only the free, blocked and out-of-range codes are produced.
    `GSC_ASSERT_NOW(a_status_code, out_valid, status <= gsc_pkg::ST_RANGE, "illegal status code")

    // The front takes one transaction at a time.
    `GSC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input accepted on consecutive cycles")

endmodule

bind grid_segment_collision_check gsc_checker u_gsc_checker (.*);
